[hw/rtl/callsign_blocklist_matcher_unit_defines.svh]
// Assertion macros for the callsign blocklist matcher.
// Included by RTL files that carry concurrent assertions; uses clk and rst.
`ifndef CALLSIGN_BLOCKLIST_MATCHER_UNIT_DEFINES_SVH
`define CALLSIGN_BLOCKLIST_MATCHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define CBM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CBM_ASSERT(lbl, prop)
`define CBM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[hw/rtl/cbm_pkg.sv]
// Shared types and helpers for the callsign blocklist matcher.
// No dependencies.
`default_nettype none
package cbm_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_CALL    = 2'd2
  } kind_t;

  // broadcast control to the row of compare cells
  typedef struct packed {
    logic       wr;     // write callsign byte into the selected cell
    logic       start;  // reload window from callsign, set match
    logic       step;   // compare window with ch, shift window left
    logic [7:0] ch;
  } cell_ctl_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61:8'h7A]}) r = c - 8'h20;
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cbm_in_if.sv]
// Input channel: kind, char_byte, last with valid/ready.
// No dependencies.
`default_nettype none
interface cbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_byte;
  logic       last;

  modport source (output valid, kind, char_byte, last, input ready);
  modport sink   (input valid, kind, char_byte, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/cbm_out_if.sv]
// Result channel: blocked flag with valid/ready.
// No dependencies.
`default_nettype none
interface cbm_out_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source (output valid, blocked, input ready);
  modport sink   (input valid, blocked, output ready);
endinterface
`default_nettype wire

[hw/rtl/cbm_cell.sv]
// One compare cell: holds a callsign byte, a sliding window byte and a match bit.
// Depends on cbm_pkg.
`default_nettype none
module cbm_cell (
  input  wire logic              clk,
  input  wire cbm_pkg::cell_ctl_t ctl,
  input  wire logic              sel,
  input  wire logic [7:0]        nbr_win,
  output logic [7:0]             win,
  output logic                   hit
);

  logic [7:0] call;

  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      call <= ctl.ch;
    end
    if (ctl.start) begin
      win <= call;
      hit <= 1'b1;
    end else if (ctl.step) begin
      hit <= hit & (win == ctl.ch);
      win <= nbr_win;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cbm_store.sv]
// Pattern table: character memory and per-pattern length/overlong memory.
// Registered reads; no dependencies.
`default_nettype none
module cbm_store #(
  parameter  int MAX_PATTERNS = 64,
  parameter  int CALL_LEN     = 10,
  localparam int DEPTH = MAX_PATTERNS * CALL_LEN,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int PIW   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1,
  localparam int LW    = $clog2(CALL_LEN + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 char_we,
  input  wire logic [AW-1:0]        char_waddr,
  input  wire logic [7:0]           char_wdata,
  input  wire logic [AW-1:0]        char_raddr,
  output logic      [7:0]           char_rdata,
  input  wire logic                 meta_we,
  input  wire logic [PIW-1:0]       meta_waddr,
  input  wire logic [LW:0]          meta_wdata,
  input  wire logic [PIW-1:0]       meta_raddr,
  output logic      [LW:0]          meta_rdata
);

  logic [7:0]  char_mem [DEPTH];
  logic [LW:0] meta_mem [MAX_PATTERNS];

  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    char_rdata <= char_mem[char_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[meta_raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/callsign_blocklist_matcher_unit.sv]
// Callsign blocklist matcher, top level.
// Clear, pattern and non-final callsign transactions are each taken in ST_IDLE.
// A final callsign byte starts a scan with input held off: per pattern a read
// setup, len compare steps and an evaluate, up to the first hit; the verdict is
// then registered from ST_DONE (reached directly from the byte if the table is empty).
// Reset empties the table and callsign; the pattern memories are not cleared.
`default_nettype none
`include "callsign_blocklist_matcher_unit_defines.svh"
module callsign_blocklist_matcher_unit #(
  parameter int MAX_PATTERNS = 64,
  parameter int CALL_LEN     = 10
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cbm_in_if.sink     cmd,
  cbm_out_if.source  verdict
);

  localparam int DEPTH = MAX_PATTERNS * CALL_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIW   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int PW    = $clog2(MAX_PATTERNS + 1);
  localparam int LW    = $clog2(CALL_LEN + 1);
  localparam logic [LW-1:0] CALL_LEN_L = LW'(CALL_LEN);
  localparam logic [PW-1:0] MAX_PAT_L  = PW'(MAX_PATTERNS);
  localparam logic [AW-1:0] STRIDE     = AW'(CALL_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,  // taking transactions
    ST_META,  // issue reads for pattern p, reload cell windows
    ST_CMP,   // one pattern byte per cycle through the cells
    ST_EVAL,  // combine cell match bits for pattern p
    ST_DONE   // hand result to the output register
  } state_t;

  state_t          state;
  logic [LW-1:0]   load_pos;
  logic [PW-1:0]   count;
  logic            too_long;
  logic [AW-1:0]   wr_base;
  logic [LW-1:0]   call_pos;
  logic [LW-1:0]   clen;
  logic [PIW-1:0]  p;
  logic [AW-1:0]   rd_base;
  logic [LW-1:0]   k;
  logic            hit;
  logic            out_valid;
  logic            out_blocked;

  // transaction decode
  logic                accept;
  cbm_pkg::kind_t      kind;
  logic [7:0]          ch_up;
  logic                full;
  logic                pat_acc;
  logic                tl_cur;
  logic                tl_new;
  logic                char_we;
  logic [LW-1:0]       load_pos_inc;
  logic                meta_we;
  logic                call_acc;
  logic [LW-1:0]       call_pos_inc;

  assign accept  = cmd.valid && cmd.ready;
  assign kind    = cbm_pkg::kind_t'(cmd.kind);
  assign ch_up   = cbm_pkg::upcase(cmd.char_byte);
  assign full    = (count == MAX_PAT_L);
  assign pat_acc = accept && (kind == cbm_pkg::KIND_PATTERN) && !full;
  assign tl_cur  = (load_pos == '0) ? 1'b0 : too_long;
  assign char_we = pat_acc && (load_pos < CALL_LEN_L);
  // bytes past the slot are dropped and flag the pattern
  assign tl_new  = tl_cur | !char_we;
  assign load_pos_inc = char_we ? load_pos + LW'(1) : load_pos;
  assign meta_we = pat_acc && cmd.last;
  assign call_acc = accept && (kind == cbm_pkg::KIND_CALL);
  assign call_pos_inc = (call_pos < CALL_LEN_L) ? call_pos + LW'(1) : call_pos;

  // pattern table
  logic [AW-1:0] char_raddr;
  logic [7:0]    char_rdata;
  logic [LW:0]   meta_rdata;
  logic [LW-1:0] plen;
  logic          tl_rd;

  assign char_raddr = rd_base + AW'(k) + ((state == ST_CMP) ? AW'(1) : AW'(0));
  assign plen  = meta_rdata[LW-1:0];
  assign tl_rd = meta_rdata[LW];

  cbm_store #(
    .MAX_PATTERNS (MAX_PATTERNS),
    .CALL_LEN     (CALL_LEN)
  ) u_store (
    .clk        (clk),
    .char_we    (char_we),
    .char_waddr (wr_base + AW'(load_pos)),
    .char_wdata (ch_up),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .meta_we    (meta_we),
    .meta_waddr (count[PIW-1:0]),
    .meta_wdata ({tl_new, load_pos_inc}),
    .meta_raddr (p),
    .meta_rdata (meta_rdata)
  );

  // row of compare cells; cell s sees callsign[s+k] at step k
  cbm_pkg::cell_ctl_t ctl;
  logic [CALL_LEN-1:0] sel;
  logic [CALL_LEN-1:0] match_vec;
  logic [CALL_LEN-1:0] pos_ok;
  logic [7:0]          win [CALL_LEN];

  always_comb begin
    ctl.wr    = call_acc;
    ctl.start = (state == ST_META);
    ctl.step  = (state == ST_CMP);
    ctl.ch    = (state == ST_CMP) ? char_rdata : ch_up;
  end

  for (genvar s = 0; s < CALL_LEN; s++) begin : g_cell
    logic [7:0] nbr;
    if (s == CALL_LEN - 1) begin : g_end
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = win[s+1];
    end
    assign sel[s] = (call_pos == LW'(s));
    // window start s fits when s + len <= callsign length
    assign pos_ok[s] = ({1'b0, LW'(s)} + {1'b0, plen}) <= {1'b0, clen};

    cbm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel     (sel[s]),
      .nbr_win (nbr),
      .win     (win[s]),
      .hit     (match_vec[s])
    );
  end

  logic hit_p;
  logic last_p;
  assign hit_p  = !tl_rd && |(match_vec & pos_ok);
  assign last_p = ((PW'(p) + PW'(1)) == count);

  assign cmd.ready       = (state == ST_IDLE);
  assign verdict.valid   = out_valid;
  assign verdict.blocked = out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      load_pos    <= '0;
      count       <= '0;
      too_long    <= 1'b0;
      wr_base     <= '0;
      call_pos    <= '0;
      clen        <= '0;
      p           <= '0;
      rd_base     <= '0;
      k           <= '0;
      hit         <= 1'b0;
      out_valid   <= 1'b0;
      out_blocked <= 1'b0;
    end else begin
      // in ST_DONE the hand-over below decides out_valid itself
      if (out_valid && verdict.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              cbm_pkg::KIND_CLEAR: begin
                count    <= '0;
                load_pos <= '0;
                wr_base  <= '0;
              end
              cbm_pkg::KIND_PATTERN: begin
                if (!full) begin
                  too_long <= tl_new;
                  if (cmd.last) begin
                    count    <= count + PW'(1);
                    load_pos <= '0;
                    wr_base  <= wr_base + STRIDE;
                  end else begin
                    load_pos <= load_pos_inc;
                  end
                end
              end
              cbm_pkg::KIND_CALL: begin
                if (cmd.last) begin
                  clen     <= call_pos_inc;
                  call_pos <= '0;
                  p        <= '0;
                  rd_base  <= '0;
                  k        <= '0;
                  if (count == '0) begin
                    hit   <= 1'b0;
                    state <= ST_DONE;
                  end else begin
                    state <= ST_META;
                  end
                end else begin
                  call_pos <= call_pos_inc;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_META: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          k <= k + LW'(1);
          if ((k + LW'(1)) == plen) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (hit_p || last_p) begin
            hit   <= hit_p;
            state <= ST_DONE;
          end else begin
            p       <= p + PIW'(1);
            rd_base <= rd_base + STRIDE;
            k       <= '0;
            state   <= ST_META;
          end
        end
        ST_DONE: begin
          if (!out_valid || verdict.ready) begin
            out_valid   <= 1'b1;
            out_blocked <= hit;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CBM_ASSERT(a_count_range, count <= MAX_PAT_L)
  `CBM_ASSERT(a_pos_range, (load_pos <= CALL_LEN_L) && (call_pos <= CALL_LEN_L))
  `CBM_ASSERT(a_result_from_done, $rose(out_valid) |-> ($past(state) == ST_DONE))
  `CBM_ASSERT(a_call_held_in_scan, (state != ST_IDLE) |=> (call_pos == $past(call_pos)))
  `CBM_ASSERT(a_scan_in_table, (state == ST_EVAL) |-> (PW'(p) < count))

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for callsign_blocklist_matcher_unit: directed cases, then random
// pattern/callsign sessions under random idling. Uses cbm_pkg, cbm_in_if, cbm_out_if and the
// unit itself; its own blocklist predictor supplies the expected verdicts.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAT  = 64;
  localparam int CALL_LEN = 10;
  // Kind encoding left unused by the block; it must be swallowed silently.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles without a single transaction on either channel before giving up. The slowest
  // scan is a full table of ten-byte patterns.
  localparam int IDLE_LIMIT = 4000;
  // Quiet cycles after the last verdict, to catch anything spurious.
  localparam int DRAIN_CYCLES = 32;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;

  cbm_in_if  cmd_if();
  cbm_out_if verdict_if();

  callsign_blocklist_matcher_unit #(
    .MAX_PATTERNS(MAX_PAT),
    .CALL_LEN    (CALL_LEN)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .verdict(verdict_if)
  );

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  logic verdict_q[$];   // blocked flags still owed by the block, oldest first
  int   n_sent;         // command transactions accepted so far
  int   n_err;          // mismatches seen
  bit   steady;         // when set, neither side idles: back-to-back transactions

  // Predictor copy of the blocklist table and the callsign being streamed.
  logic [7:0] tbl_chars[MAX_PAT][CALL_LEN];
  int         tbl_len[MAX_PAT];
  bit         tbl_long[MAX_PAT];
  int         tbl_cnt;
  int         load_pos;
  logic [7:0] call_buf[CALL_LEN];
  int         call_pos;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Blocklist predictor. Applies one accepted command transaction to the
  // bench's own table and returns 1 when a verdict is due, with the verdict in
  // hit. Only lower-case ASCII letters are folded; every other byte, zero
  // included, is an ordinary character.
  // ---------------------------------------------------------------------------
  function automatic bit blocklist_step(input logic [1:0] k, input logic [7:0] raw,
                                        input logic fin, output logic hit);
    logic [7:0] c;
    bit         same;
    c   = raw;
    hit = 1'b0;
    if (raw >= "a" && raw <= "z") c[5] = 1'b0;
    case (k)
      cbm_pkg::KIND_CLEAR: begin
        // table emptied and any half-loaded pattern dropped; callsign kept
        tbl_cnt  = 0;
        load_pos = 0;
      end
      cbm_pkg::KIND_PATTERN: begin
        // a full table ignores pattern bytes until the next clear
        if (tbl_cnt < MAX_PAT) begin
          if (load_pos == 0) tbl_long[tbl_cnt] = 1'b0;
          if (load_pos < CALL_LEN) begin
            tbl_chars[tbl_cnt][load_pos] = c;
            load_pos++;
          end else begin
            // overlong: excess bytes dropped, pattern can never match
            tbl_long[tbl_cnt] = 1'b1;
          end
          if (fin) begin
            tbl_len[tbl_cnt] = load_pos;
            tbl_cnt++;
            load_pos = 0;
          end
        end
      end
      cbm_pkg::KIND_CALL: begin
        // overlong callsign: only its first CALL_LEN bytes count
        if (call_pos < CALL_LEN) begin
          call_buf[call_pos] = c;
          call_pos++;
        end
        if (fin) begin
          for (int p = 0; p < tbl_cnt; p++) begin
            if (!tbl_long[p] && tbl_len[p] != 0 && tbl_len[p] <= call_pos) begin
              for (int s = 0; s + tbl_len[p] <= call_pos; s++) begin
                same = 1'b1;
                for (int j = 0; j < tbl_len[p]; j++)
                  if (tbl_chars[p][j] != call_buf[s + j]) same = 1'b0;
                if (same) hit = 1'b1;
              end
            end
          end
          call_pos = 0;
          return 1'b1;
        end
      end
      default: ;  // unused kind: no effect at all
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting: one line per mismatch.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("tb_top: mismatch at %0t: %s (got %b, want %b)", $realtime, what, got, want);
    n_err++;
  endtask

  // ---------------------------------------------------------------------------
  // Command source. Unless steady, it first idles at random; it then presents
  // the transaction and holds it until ready is seen. Ready is looked at on the
  // falling edge, so acceptance at the next rising edge is known without
  // relying on event order; the predictor then runs on the accepted item.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] k, input logic [7:0] c, input logic fin);
    int   gap;
    logic hit;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.kind      <= k;
    cmd_if.char_byte <= c;
    cmd_if.last      <= fin;
    do @(negedge clk); while (!cmd_if.ready);
    @(posedge clk);
    if (blocklist_step(k, c, fin, hit)) verdict_q = {verdict_q, hit};
    n_sent++;
  endtask

  // A whole pattern or callsign, last flagged on its final byte.
  task automatic send_word(input logic [1:0] k, input byte_q_t w);
    foreach (w[i]) send_item(k, w[i], i == w.size() - 1);
  endtask

  function automatic byte_q_t text(input string s);
    byte_q_t w;
    for (int i = 0; i < s.len(); i++) w = {w, 8'(s[i])};
    return w;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly A-D in either case so that hits are common; now and then any byte.
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return rand_byte();
    c = 8'("A" + $urandom_range(0, 3));
    if ($urandom_range(0, 1) == 1) c[5] = 1'b1;
    return c;
  endfunction

  function automatic byte_q_t rand_word(input int len);
    byte_q_t w;
    repeat (len) w = {w, rand_char()};
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Verdict sink and checker. Unless steady, ready drops at random before each
  // verdict; each accepted verdict is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin : verdict_sink
    int   stall;
    logic want;
    verdict_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        verdict_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      verdict_if.ready <= 1'b1;
      do @(negedge clk); while (!verdict_if.valid);
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with nothing outstanding", verdict_if.blocked, 1'bx);
      end else begin
        want = verdict_q.pop_front();
        if (verdict_if.blocked !== want)
          report_mismatch("blocked flag", verdict_if.blocked, want);
      end
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transaction on either channel restarts the count.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (verdict_if.valid && verdict_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table never blocks; a zero byte is just a character.
  task automatic test_empty_table();
    send_item(cbm_pkg::KIND_CALL, 8'h00, 1'b1);
  endtask

  // Unused kind with every other field at its top value: no verdict, no change.
  task automatic test_unused_kind();
    send_item(KIND_UNUSED, 8'hFF, 1'b1);
  endtask

  // Folding covers a-z only; the bytes either side of that range stay put.
  task automatic test_case_folding();
    send_word(cbm_pkg::KIND_PATTERN, text("az"));
    send_item(cbm_pkg::KIND_PATTERN, 8'hFF, 1'b1);
    send_word(cbm_pkg::KIND_PATTERN, text("`{"));
    send_word(cbm_pkg::KIND_CALL, text("xAZ"));   // hit on "AZ"
    send_word(cbm_pkg::KIND_CALL, text("`{"));    // hit, unfolded
    send_word(cbm_pkg::KIND_CALL, text("@["));    // no hit: no folding of the neighbours
    send_item(cbm_pkg::KIND_CALL, 8'hFF, 1'b1);   // hit on the single 0xFF pattern
  endtask

  // A callsign mid-pattern leaves the partial pattern pending until its own last byte.
  task automatic test_interleaved_pattern();
    send_item(cbm_pkg::KIND_PATTERN, "q", 1'b0);
    send_item(cbm_pkg::KIND_CALL, "Q", 1'b1);     // "Q" not committed yet
    send_item(cbm_pkg::KIND_PATTERN, "R", 1'b1);
    send_word(cbm_pkg::KIND_CALL, text("QR"));
  endtask

  // Clear empties the table: nothing matches afterwards.
  task automatic test_clear();
    send_item(cbm_pkg::KIND_CLEAR, 8'h00, 1'b0);
    send_item(cbm_pkg::KIND_CALL, 8'hFF, 1'b1);
  endtask

  // Fill the table past its capacity: the extra patterns are dropped, and a
  // hit on the last stored entry still needs the whole table scanned.
  task automatic test_table_full();
    steady = 1'b0;
    send_item(cbm_pkg::KIND_CLEAR, rand_byte(), 1'b1);
    for (int i = 0; i < MAX_PAT - 1; i++) send_word(cbm_pkg::KIND_PATTERN, text("ZZZ"));
    send_word(cbm_pkg::KIND_PATTERN, text("KW"));        // last stored entry
    send_word(cbm_pkg::KIND_PATTERN, text("XY"));        // dropped
    send_item(cbm_pkg::KIND_PATTERN, rand_byte(), 1'b0); // dropped
    send_word(cbm_pkg::KIND_CALL, text("AKWB"));         // hit on the last entry
    send_word(cbm_pkg::KIND_CALL, text("XY"));           // no hit
    send_word(cbm_pkg::KIND_CALL, text("zzzzzzzzzzzz")); // overlong callsign, hit
    send_item(cbm_pkg::KIND_CLEAR, rand_byte(), 1'b0);
  endtask

  // Random sessions: mostly clear, load a few patterns, stream a few callsigns;
  // roughly one session in three adds noise. Some sessions run with no idling.
  task automatic test_random_traffic(input int quota);
    int stop_at;
    int len;
    stop_at = n_sent + quota;
    while (n_sent < stop_at) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) send_item(cbm_pkg::KIND_CLEAR, rand_byte(), 1'($urandom));
      repeat ($urandom_range(0, 6)) begin
        // occasional overlong pattern
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 13) : $urandom_range(1, 4);
        send_word(cbm_pkg::KIND_PATTERN, rand_word(len));
      end
      repeat ($urandom_range(1, 5)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 8);
        send_word(cbm_pkg::KIND_CALL, rand_word(len));
      end
      case ($urandom_range(0, 11))
        0: send_item(KIND_UNUSED, rand_byte(), 1'($urandom));
        1: begin
          // half a pattern abandoned by a clear
          send_word(cbm_pkg::KIND_PATTERN, rand_word($urandom_range(1, 3)));
          send_item(cbm_pkg::KIND_PATTERN, rand_char(), 1'b0);
          send_item(cbm_pkg::KIND_CLEAR, rand_byte(), 1'($urandom));
        end
        2: begin
          // callsign streamed while a pattern is half loaded
          send_item(cbm_pkg::KIND_PATTERN, rand_char(), 1'b0);
          send_word(cbm_pkg::KIND_CALL, rand_word($urandom_range(1, 6)));
          send_item(cbm_pkg::KIND_PATTERN, rand_char(), 1'b1);
          send_word(cbm_pkg::KIND_CALL, rand_word($urandom_range(2, 8)));
        end
        3: repeat ($urandom_range(1, 4))
             send_item(2'($urandom_range(0, 3)), rand_byte(), 1'($urandom));
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    n_sent   = 0;
    n_err    = 0;
    steady   = 1'b0;
    tbl_cnt  = 0;
    load_pos = 0;
    call_pos = 0;

    rst                 <= 1'b1;
    cmd_if.valid        <= 1'b0;
    cmd_if.kind         <= cbm_pkg::KIND_CLEAR;
    cmd_if.char_byte    <= 8'h00;
    cmd_if.last         <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_unused_kind();
    test_case_folding();
    test_interleaved_pattern();
    test_clear();
    test_table_full();
    test_random_traffic(1150);

    cmd_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_err == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
